// ===== rtl/btpc_pkg.sv =====
// Package for barometric compensation: register indexes, coefficient types, widths.
// No dependencies.
`timescale 1ns / 1ps
package btpc_pkg;
	localparam int RawW = 20;
	localparam int RegW = 48;
	localparam int IdxW = 2;
	localparam int DivW = 64;
	localparam int SideW = 17;

	typedef enum logic [IdxW-1:0] {
		REG_TEMP = 2'd0,
		REG_P123 = 2'd1,
		REG_P456 = 2'd2,
		REG_P789 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} coeffs_t;

	typedef struct packed {
		logic [RawW-1:0] raw_temperature;
		logic [RawW-1:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
	} out_item_t;
endpackage

// ===== rtl/btpc_if.sv =====
// Valid/ready channel interfaces for input, output and configuration.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
interface btpc_in_if import btpc_pkg::*; ();
	logic valid;
	logic ready;
	logic [RawW-1:0] raw_temperature;
	logic [RawW-1:0] raw_pressure;
	modport source(output valid, raw_temperature, raw_pressure, input ready);
	modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btpc_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] temperature_centi;
	logic [31:0] pressure_q24_8;
	modport source(output valid, temperature_centi, pressure_q24_8, input ready);
	modport sink(input valid, temperature_centi, pressure_q24_8, output ready);
endinterface

interface btpc_cfg_if import btpc_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [RegW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/btpc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, with sideband.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
module btpc_div import btpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [DivW-1:0]      num,
	input  logic [DivW-1:0]      den,
	input  logic [SideW-1:0]     side_in,
	output logic                 out_valid,
	output logic [DivW-1:0]      quot,
	output logic [SideW-1:0]     side_out
);
	// Stage arrays: remainder, partial quotient/dividend, divisor magnitude.
	logic [DivW:0]   rem_s   [DivW+1];
	logic [DivW-1:0] qd_s    [DivW+1];
	logic [DivW-1:0] md_s    [DivW+1];
	logic            neg_s   [DivW+1];
	logic            v_s     [DivW+1];
	logic [SideW-1:0] side_s [DivW+1];

	// Entry stage takes magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			qd_s[0]   <= num[DivW-1] ? (DivW'(0) - num) : num;
			md_s[0]   <= den[DivW-1] ? (DivW'(0) - den) : den;
			neg_s[0]  <= num[DivW-1] ^ den[DivW-1];
			side_s[0] <= side_in;
		end
	end

	// Restoring steps, one bit per stage.
	for (genvar g = 0; g < DivW; g++) begin : g_step
		logic [DivW:0] sh;
		logic [DivW:0] diff;
		assign sh   = {rem_s[g][DivW-1:0], qd_s[g][DivW-1]};
		assign diff = sh - {1'b0, md_s[g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= diff[DivW] ? sh : diff;
				qd_s[g+1]   <= {qd_s[g][DivW-2:0], ~diff[DivW]};
				md_s[g+1]   <= md_s[g];
				neg_s[g+1]  <= neg_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = v_s[DivW];
	assign quot      = neg_s[DivW] ? (DivW'(0) - qd_s[DivW]) : qd_s[DivW];
	assign side_out  = side_s[DivW];
endmodule

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Channel    | dir | payload
// in_ch      | in  | raw_temperature[19:0], raw_pressure[19:0]
// out_ch     | out | temperature_centi[15:0] signed, pressure_q24_8[31:0]
// cfg_ch     | in  | index[7:0], data[47:0]
// One reading pair enters per cycle while the pipe advances; the path is 8 front
// stages, 65 divider stages and 6 back stages including the output register.
// The whole pipe advances only when the output register is free or taken, so
// a stall holds every stage. Reset clears valid bits and coefficients.
// Products are at most 64x16 or 33x33 bits; the square of the scaled pressure
// is built from 32x32 partial products.
// Depends on btpc_pkg, btpc_if and btpc_div.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation import btpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	btpc_in_if.sink   in_ch,
	btpc_out_if.source out_ch,
	btpc_cfg_if.sink  cfg_ch
);
	// Coefficient registers.
	logic [RegW-1:0] reg_q [4];
	coeffs_t c;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) reg_q[i] <= '0;
		end else if (cfg_ch.valid && cfg_ch.index < 8'd4) begin
			reg_q[cfg_ch.index[IdxW-1:0]] <= cfg_ch.data;
		end
	end
	always_comb begin
		c.t1 = reg_q[REG_TEMP][15:0];  c.t2 = reg_q[REG_TEMP][31:16];
		c.t3 = reg_q[REG_TEMP][47:32];
		c.p1 = reg_q[REG_P123][15:0];  c.p2 = reg_q[REG_P123][31:16];
		c.p3 = reg_q[REG_P123][47:32];
		c.p4 = reg_q[REG_P456][15:0];  c.p5 = reg_q[REG_P456][31:16];
		c.p6 = reg_q[REG_P456][47:32];
		c.p7 = reg_q[REG_P789][15:0];  c.p8 = reg_q[REG_P789][31:16];
		c.p9 = reg_q[REG_P789][47:32];
	end

	// Global advance: output register empty or being taken.
	logic en;
	logic out_v_q;
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: temperature differences.
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8;
	logic signed [20:0] dx_s1, dy_s1;
	logic [RawW-1:0] adp_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8} <= '0;
		end else if (en) begin
			v1_s1 <= in_ch.valid; v2_s2 <= v1_s1; v3_s3 <= v2_s2; v4_s4 <= v3_s3;
			v5_s5 <= v4_s4; v6_s6 <= v5_s5; v7_s7 <= v6_s6; v8_s8 <= v7_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({4'b0, in_ch.raw_temperature[19:3]}) -
				$signed({4'b0, c.t1, 1'b0});
			dy_s1  <= $signed({5'b0, in_ch.raw_temperature[19:4]}) - $signed({5'b0, c.t1});
			adp_s1 <= in_ch.raw_pressure;
		end
	end

	// Stage 2: products.
	logic signed [37:0] a_s2;
	logic signed [41:0] sq_s2;
	logic [RawW-1:0] adp_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= 38'(dx_s1 * c.t2);
			sq_s2  <= 42'(dy_s1 * dy_s1);
			adp_s2 <= adp_s1;
		end
	end

	// Stage 3: t3 term.
	logic signed [26:0] a_s3;
	logic signed [45:0] b_s3;
	logic [RawW-1:0] adp_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= 27'(a_s2 >>> 11);
			b_s3   <= 46'($signed(sq_s2 >>> 12) * c.t3);
			adp_s3 <= adp_s2;
		end
	end

	// Stage 4: t_fine and temperature output.
	logic signed [31:0] tf_s4;
	logic signed [15:0] tc_s4;
	logic [RawW-1:0] adp_s4;
	logic signed [32:0] tfw;
	logic signed [35:0] tv;
	assign tfw = 33'(a_s3) + 33'(b_s3 >>> 14);
	assign tv  = (36'(tfw) * 36'sd5 + 36'sd128) >>> 8;
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s4  <= 32'(tfw);
			tc_s4  <= (tv > 36'sd32767) ? 16'sd32767 :
				(tv < -36'sd32768) ? -16'sd32768 : 16'(tv);
			adp_s4 <= adp_s3;
		end
	end

	// Stage 5: x = t_fine - 128000 and its square.
	logic signed [32:0] x_s5;
	logic signed [63:0] xx_s5;
	logic signed [15:0] tc_s5;
	logic [RawW-1:0] adp_s5;
	logic signed [32:0] xw;
	assign xw = 33'(tf_s4) - 33'sd128000;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s5   <= xw;
			xx_s5  <= 64'(xw * xw);
			tc_s5  <= tc_s4; adp_s5 <= adp_s4;
		end
	end

	// Stage 6: coefficient products of the square and linear terms.
	logic [63:0] x6_s6, x3_s6, x5_s6, x2_s6;
	logic signed [15:0] tc_s6;
	logic [RawW-1:0] adp_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			x6_s6 <= 64'(xx_s5 * c.p6);
			x3_s6 <= 64'(xx_s5 * c.p3);
			x5_s6 <= 64'(x_s5 * c.p5);
			x2_s6 <= 64'(x_s5 * c.p2);
			tc_s6 <= tc_s5; adp_s6 <= adp_s5;
		end
	end

	// Stage 7: sums b and a.
	logic [63:0] b_s7, av_s7;
	logic signed [15:0] tc_s7;
	logic [RawW-1:0] adp_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			b_s7  <= x6_s6 + (x5_s6 << 17) + (64'(c.p4) << 35);
			av_s7 <= 64'($signed(x3_s6) >>> 8) + (x2_s6 << 12) + (64'd1 << 47);
			tc_s7 <= tc_s6; adp_s7 <= adp_s6;
		end
	end

	// Stage 8: divisor and numerator products.
	logic [63:0] d_s8, n_s8;
	logic signed [15:0] tc_s8;
	logic [63:0] pw;
	assign pw = 64'(av_s7 * {48'b0, c.p1});
	always_ff @(posedge clk) begin
		if (en) begin
			d_s8  <= 64'($signed(pw) >>> 33);
			n_s8  <= 64'((((64'd1048576 - 64'(adp_s7)) << 31) - b_s7) * 64'd3125);
			tc_s8 <= tc_s7;
		end
	end

	// Divider with temperature and zero flag on the side.
	logic dv;
	logic [63:0] q;
	logic [SideW-1:0] side_o;
	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v8_s8),
		.num(n_s8), .den(d_s8),
		.side_in({d_s8 == 64'd0, tc_s8}),
		.out_valid(dv), .quot(q), .side_out(side_o)
	);

	// Back stages: compensation polynomial, square from 32x32 partial products.
	logic [63:0] p13_b1, p_b1, ll_b2, p8_b2, p_b2, pp_b3, b_b3, p_b3;
	logic [63:0] a_b4, b_b4, p_b4, pr_b5;
	logic [31:0] hl_b2;
	logic [SideW-1:0] sd_b1, sd_b2, sd_b3, sd_b4, sd_b5;
	logic v_b1, v_b2, v_b3, v_b4, v_b5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_b1, v_b2, v_b3, v_b4, v_b5} <= '0;
		end else if (en) begin
			v_b1 <= dv; v_b2 <= v_b1; v_b3 <= v_b2; v_b4 <= v_b3; v_b5 <= v_b4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p13_b1 <= 64'($signed(q) >>> 13); p_b1 <= q; sd_b1 <= side_o;
			ll_b2  <= 64'(p13_b1[31:0] * p13_b1[31:0]);
			hl_b2  <= p13_b1[31:0] * p13_b1[63:32];
			p8_b2  <= 64'($signed(p_b1) * c.p8);
			p_b2   <= p_b1; sd_b2 <= sd_b1;
			pp_b3  <= ll_b2 + {hl_b2[30:0], 33'b0};
			b_b3   <= 64'($signed(p8_b2) >>> 19);
			p_b3   <= p_b2; sd_b3 <= sd_b2;
			a_b4   <= 64'($signed(64'(pp_b3 * 64'(c.p9))) >>> 25);
			b_b4   <= b_b3; p_b4 <= p_b3; sd_b4 <= sd_b3;
			pr_b5  <= 64'($signed(p_b4 + a_b4 + b_b4) >>> 8) + (64'(c.p7) << 4);
			sd_b5  <= sd_b4;
		end
	end

	// Output register.
	out_item_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_b5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.temperature_centi <= sd_b5[15:0];
			out_q.pressure_q24_8    <= sd_b5[16] ? 32'd0 : pr_b5[31:0];
		end
	end
	assign out_ch.valid             = out_v_q;
	assign out_ch.temperature_centi = out_q.temperature_centi;
	assign out_ch.pressure_q24_8    = out_q.pressure_q24_8;
endmodule

// ===== tb/baro_temp_pressure_compensation_tb.sv =====
// Self-checking bench for the barometric compensation pipeline: drives reading pairs
// and coefficient writes, predicts each result in 64-bit arithmetic and compares in order.
// Depends on btpc_pkg, btpc_if and the block baro_temp_pressure_compensation.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_tb;
	import btpc_pkg::*;

	localparam int Latency = 79;
	localparam longint CycleLimit = 400000;
	localparam int MaxReports = 10;

	// One row of the directed table; has_exp marks rows with a typed-in result.
	typedef struct {
		logic [RawW-1:0] raw_t;
		logic [RawW-1:0] raw_p;
		bit has_exp;
		logic signed [15:0] exp_t;
		logic [31:0] exp_p;
	} row_t;

	logic clk;
	logic arst_n;
	btpc_in_if in_ch();
	btpc_out_if out_ch();
	btpc_cfg_if cfg_ch();

	baro_temp_pressure_compensation u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// Predictor copy of the coefficient registers.
	logic [RegW-1:0] coef_reg [4];
	out_item_t expected_results [$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle counter with a hard stop.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("baro_temp_pressure_compensation regression: fail");
				$finish;
			end
		end
	end

	function automatic longint sfld(logic [RegW-1:0] r, int pos);
		logic signed [15:0] v;
		v = r[pos +: 16];
		return longint'(v);
	endfunction

	// Compensation arithmetic at 64 bits, wrapping, with arithmetic right shifts.
	function automatic out_item_t compensate(logic [RawW-1:0] raw_t, logic [RawW-1:0] raw_p);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint a, b, tf, tv, d, num, p, press, adc_t, adc_p;
		longint unsigned ma, md, q;
		out_item_t r;
		adc_t = longint'({44'd0, raw_t});
		adc_p = longint'({44'd0, raw_p});
		t1 = longint'({48'd0, coef_reg[REG_TEMP][15:0]});
		t2 = sfld(coef_reg[REG_TEMP], 16);
		t3 = sfld(coef_reg[REG_TEMP], 32);
		p1 = longint'({48'd0, coef_reg[REG_P123][15:0]});
		p2 = sfld(coef_reg[REG_P123], 16);
		p3 = sfld(coef_reg[REG_P123], 32);
		p4 = sfld(coef_reg[REG_P456], 0);
		p5 = sfld(coef_reg[REG_P456], 16);
		p6 = sfld(coef_reg[REG_P456], 32);
		p7 = sfld(coef_reg[REG_P789], 0);
		p8 = sfld(coef_reg[REG_P789], 16);
		p9 = sfld(coef_reg[REG_P789], 32);

		a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		b = (adc_t >>> 4) - t1;
		b = (((b * b) >>> 12) * t3) >>> 14;
		tf = a + b;
		tv = (tf * 5 + 128) >>> 8;
		if (tv < -32768) r.temperature_centi = 16'sh8000;
		else if (tv > 32767) r.temperature_centi = 16'sh7fff;
		else r.temperature_centi = tv[15:0];

		a = tf - 128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		d = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (d == 0) begin
			press = 0;
		end else begin
			num = (((64'sd1048576 - adc_p) <<< 31) - b) * 3125;
			ma = num[63] ? -num : num;
			md = d[63] ? -d : d;
			q = ma / md;
			p = (num[63] != d[63]) ? -q : q;
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			press = ((p + a + b) >>> 8) + (p7 <<< 4);
		end
		r.pressure_q24_8 = press[31:0];
		return r;
	endfunction

	// Receiver side: random stall, in-order compare against the expectation queue.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("unexpected result t=%0d p=%0h", out_ch.temperature_centi,
							out_ch.pressure_q24_8);
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (e.temperature_centi !== out_ch.temperature_centi ||
							e.pressure_q24_8 !== out_ch.pressure_q24_8) begin
						mismatches++;
						if (mismatches <= MaxReports)
							$display("mismatch: expected t=%0d p=%0h, got t=%0d p=%0h",
								e.temperature_centi, e.pressure_q24_8,
								out_ch.temperature_centi, out_ch.pressure_q24_8);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Send one reading pair; valid stays high across back-to-back requests.
	// A register write request left pending by write_reg is dropped here.
	task automatic send_reading(logic [RawW-1:0] raw_t, logic [RawW-1:0] raw_p);
		cfg_ch.valid <= 1'b0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_temperature <= raw_t;
		in_ch.raw_pressure <= raw_p;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_results.push_back(compensate(raw_t, raw_p));
	endtask

	// Wait for the pipe to drain, then a latency margin.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	// Register write; only called while the pipe is empty. Valid stays high
	// across back-to-back writes and is dropped by the next reading request.
	task automatic write_reg(logic [7:0] idx, logic [RegW-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx < 4) coef_reg[idx[1:0]] = value;
	endtask

	// Typical sensor calibration, with a random spread on each field.
	function automatic logic [RegW-1:0] pack3(int a, int b, int c);
		logic [15:0] x, y, z;
		x = 16'(a); y = 16'(b); z = 16'(c);
		return {z, y, x};
	endfunction

	task automatic write_typical();
		write_reg(8'(REG_TEMP), pack3(27504 + $urandom_range(2000) - 1000,
			26435 + $urandom_range(2000) - 1000, -1000 + $urandom_range(200) - 100));
		write_reg(8'(REG_P123), pack3(36477 + $urandom_range(2000) - 1000,
			-10685 + $urandom_range(400) - 200, 3024 + $urandom_range(100) - 50));
		write_reg(8'(REG_P456), pack3(2855 + $urandom_range(200) - 100,
			140 + $urandom_range(40) - 20, -7 + $urandom_range(4) - 2));
		write_reg(8'(REG_P789), pack3(15500 + $urandom_range(400) - 200,
			-14600 + $urandom_range(400) - 200, 6000 + $urandom_range(200) - 100));
	endtask

	task automatic write_random_regs();
		for (int i = 0; i < 4; i++)
			write_reg(8'(i), RegW'({$urandom(), $urandom()}));
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7)
				send_reading(RawW'(519888 + $urandom_range(100000) - 50000),
					RawW'(415148 + $urandom_range(200000) - 100000));
			else
				send_reading(RawW'($urandom()), RawW'($urandom()));
		end
	endtask

	row_t stim_table [4] = '{
		// Reset coefficients: divisor zero, temperature zero.
		'{20'h00000, 20'h00000, 1'b1, 16'sd0, 32'd0},
		'{20'hFFFFF, 20'hFFFFF, 1'b1, 16'sd0, 32'd0},
		'{20'h55555, 20'hAAAAA, 1'b1, 16'sd0, 32'd0},
		'{20'hAAAAA, 20'h55555, 1'b1, 16'sd0, 32'd0}
	};
	row_t cal_table [7] = '{
		'{20'd519888, 20'd415148, 1'b0, 16'sd0, 32'd0},
		'{20'h00000, 20'h00000, 1'b0, 16'sd0, 32'd0},
		'{20'hFFFFF, 20'hFFFFF, 1'b0, 16'sd0, 32'd0},
		'{20'h00000, 20'hFFFFF, 1'b0, 16'sd0, 32'd0},
		'{20'hFFFFF, 20'h00000, 1'b0, 16'sd0, 32'd0},
		'{20'h55555, 20'hAAAAA, 1'b0, 16'sd0, 32'd0},
		'{20'hAAAAA, 20'h55555, 1'b0, 16'sd0, 32'd0}
	};

	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		send_idle_pct = 20;
		recv_idle_pct = 85;
		for (int i = 0; i < 4; i++) coef_reg[i] = '0;
		in_ch.valid <= 1'b0;
		in_ch.raw_temperature <= '0;
		in_ch.raw_pressure <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, typed-in results.
		foreach (stim_table[i]) begin
			send_reading(stim_table[i].raw_t, stim_table[i].raw_p);
			if (stim_table[i].has_exp) begin
				expected_results[$].temperature_centi = stim_table[i].exp_t;
				expected_results[$].pressure_q24_8 = stim_table[i].exp_p;
			end
		end
		drain();

		// Typical calibration, then extreme coefficients (saturation, wrap).
		write_typical();
		foreach (cal_table[i]) send_reading(cal_table[i].raw_t, cal_table[i].raw_p);
		drain();
		write_reg(8'(REG_TEMP), {16'h7fff, 16'h7fff, 16'h0000});
		write_reg(8'(REG_P123), 48'hFFFF_FFFF_FFFF);
		write_reg(8'(REG_P456), {16'h8000, 16'h8000, 16'h8000});
		write_reg(8'(REG_P789), {16'h7fff, 16'h8000, 16'h7fff});
		write_reg(8'd4, 48'h1234_5678_9abc);
		write_reg(8'hFF, 48'hFFFF_FFFF_FFFF);
		foreach (cal_table[i]) send_reading(cal_table[i].raw_t, cal_table[i].raw_p);
		drain();
		write_reg(8'(REG_TEMP), {16'h8000, 16'h8000, 16'hFFFF});
		foreach (cal_table[i]) send_reading(cal_table[i].raw_t, cal_table[i].raw_p);
		drain();

		// Random phases over the three idling patterns.
		write_typical();
		send_random(250);
		drain();
		send_idle_pct = 85;
		recv_idle_pct = 20;
		write_random_regs();
		send_random(80);
		drain();
		write_typical();
		send_random(220);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_random_regs();
		send_random(80);
		drain();
		write_typical();
		send_random(300);
		drain();

		if (mismatches == 0 && expected_results.size() == 0)
			$display("baro_temp_pressure_compensation regression: pass");
		else
			$display("baro_temp_pressure_compensation regression: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/btpc_pkg.sv
rtl/btpc_if.sv
rtl/btpc_div.sv
rtl/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
